[hdl/phh_pkg.sv]
// Package for the hot-spot profiler: sizes, opcodes, result kinds.
// No dependencies.
`timescale 1ns / 1ps
package phh_pkg;
    localparam int SLOTS = 16;
    localparam int TOP_N = 8;
    localparam int LIMIT = (TOP_N < SLOTS) ? TOP_N : SLOTS;
    localparam int SW = $clog2(SLOTS);
    localparam int LW = $clog2(LIMIT + 1);
    localparam logic OP_BRANCH = 1'b0;
    localparam logic OP_DUMP = 1'b1;
    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_ENTRY = 1'b1;
    localparam logic [4:0] PERIOD_RESET = 5'd8;
    localparam logic [4:0] PERIOD_MAX = 5'd16;

    typedef struct packed {
        logic        sample;
        logic        clear;
        logic [31:0] pc;
    } t_cell_cmd;
endpackage

[hdl/phh_cell.sv]
// One slot of the profiler table; match and free status passed along the chain.
// Depends on phh_pkg.
`timescale 1ns / 1ps
module phh_cell import phh_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cell_cmd   i_cmd,
    input  logic        i_hit_in,
    input  logic        i_free_in,
    output logic        o_hit_out,
    output logic        o_free_out,
    input  logic        i_wr,
    input  logic [31:0] i_wr_pc,
    input  logic [31:0] i_wr_cnt,
    output logic [31:0] o_pc,
    output logic [31:0] o_cnt
);
    logic [31:0] r_pc, r_cnt;
    logic        live, hit;

    assign live = (r_cnt != 32'd0);
    assign hit = live && (r_pc == i_cmd.pc);
    assign o_hit_out = i_hit_in | hit;
    assign o_free_out = i_free_in | !live;
    assign o_pc = r_pc;
    assign o_cnt = r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_pc <= 32'd0;
            r_cnt <= 32'd0;
        end else if (i_wr) begin
            r_pc <= i_wr_pc;
            r_cnt <= i_wr_cnt;
        end else if (i_cmd.sample) begin
            if (hit && !i_hit_in) begin
                r_cnt <= r_cnt + 32'd1;
            end
        end
    end
endmodule

[hdl/pc_hotspot_histogram_top.sv]
// Top level of the hot-spot profiler: sampling, cell chain, dump sequencer.
// Depends on phh_pkg and phh_cell.
//
//  channel | signals                                   | handshake
//  command | i_opcode, i_prog_counter                  | i_start & !o_busy
//  config  | i_cfg_we, i_cfg_data                      | i_cfg_we
//  result  | o_kind .. o_last                          | o_valid, one cycle
//
// Busy stays low for a branch event, so events may come every cycle while no
// dump is running. A dump holds busy high through the summing state (header
// strobed after it), then one selection pass per reported entry (one pass with
// no entry for an empty table), then a clearing state. Reset clears the table
// and the event, sample and eviction counters. The receiver cannot stall.
`timescale 1ns / 1ps
module pc_hotspot_histogram_top import phh_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_opcode,
    input  logic [31:0] i_prog_counter,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_data,
    output logic        o_valid,
    output logic        o_kind,
    output logic [31:0] o_entry_pc,
    output logic [31:0] o_entry_count,
    output logic [31:0] o_sample_count,
    output logic [31:0] o_samples_evicted,
    output logic [31:0] o_total_count,
    output logic        o_last
);
    localparam logic [1:0] ST_IDLE = 2'd0, ST_SUM = 2'd1, ST_SCAN = 2'd2, ST_CLR = 2'd3;

    logic [1:0]  r_st;
    logic [4:0]  r_period;
    logic [15:0] r_evt, n_evt;
    logic [31:0] r_taken, r_evict, r_tot;
    logic [SW-1:0] r_j, r_best;
    logic [SW-1:0] r_i;
    logic [LW-1:0] r_pass;
    logic [31:0] r_bcnt;

    t_cell_cmd cmd;
    logic [SLOTS:0] hit_c, free_c;
    logic [31:0] c_pc [SLOTS];
    logic [31:0] c_cnt [SLOTS];
    logic [SLOTS-1:0] wr;
    logic [31:0] wr_pc [SLOTS];
    logic [31:0] wr_cnt [SLOTS];
    logic [15:0] mask;
    logic [4:0]  k;
    logic        accept, do_sample, swap_now;
    logic [SLOTS-1:0] first_free;
    logic [31:0] fin_cnt;
    logic [SW-1:0] fin_best;
    logic        nxt_zero, any_live, pass_last, n_valid;

    assign accept = i_start && !o_busy;
    assign o_busy = (r_st != ST_IDLE);
    assign k = (r_period > PERIOD_MAX) ? PERIOD_MAX : r_period;
    assign mask = 16'((17'd1 << k) - 17'd1);
    assign n_evt = r_evt + 16'd1;
    assign do_sample = accept && (i_opcode == OP_BRANCH) && ((n_evt & mask) == 16'd0);
    assign cmd.sample = do_sample;
    assign cmd.clear = (r_st == ST_CLR);
    assign cmd.pc = i_prog_counter;
    assign hit_c[0] = 1'b0;
    assign free_c[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++) begin : g_cell
            assign first_free[g] = (c_cnt[g] == 32'd0) && !free_c[g];
            phh_cell u_cell (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
                .i_hit_in(hit_c[g]), .i_free_in(free_c[g]),
                .o_hit_out(hit_c[g+1]), .o_free_out(free_c[g+1]),
                .i_wr(wr[g]), .i_wr_pc(wr_pc[g]), .i_wr_cnt(wr_cnt[g]),
                .o_pc(c_pc[g]), .o_cnt(c_cnt[g])
            );
        end
    endgenerate

    // pass end: swap best into slot i
    assign swap_now = (r_st == ST_SCAN) && (r_j == SW'(SLOTS - 1));
    always_comb begin
        fin_best = r_best;
        fin_cnt = r_bcnt;
        if (r_j == r_i) begin
            fin_best = r_j;
            fin_cnt = c_cnt[r_j];
        end else if (c_cnt[r_j] > r_bcnt) begin
            fin_best = r_j;
            fin_cnt = c_cnt[r_j];
        end
    end

    always_comb begin
        any_live = 1'b0;
        for (int s = 0; s < SLOTS; s++) begin
            if (c_cnt[s] != 32'd0) any_live = 1'b1;
        end
    end

    // no nonzero count left beyond slot i once this pick is swapped in
    always_comb begin
        nxt_zero = 1'b1;
        for (int s = 0; s < SLOTS; s++) begin
            if (SW'(s) > r_i) begin
                if (SW'(s) == fin_best) begin
                    if (c_cnt[r_i] != 32'd0) nxt_zero = 1'b0;
                end else if (c_cnt[s] != 32'd0) begin
                    nxt_zero = 1'b0;
                end
            end
        end
    end

    assign pass_last = (r_pass == LW'(LIMIT - 1)) || (r_i == SW'(SLOTS - 1)) || nxt_zero;
    assign n_valid = ((r_st == ST_SUM) && (r_j == SW'(SLOTS - 1))) ||
                     (swap_now && (fin_cnt != 32'd0));

    always_comb begin
        for (int s = 0; s < SLOTS; s++) begin
            wr[s] = 1'b0;
            wr_pc[s] = i_prog_counter;
            wr_cnt[s] = 32'd1;
            if (do_sample && !hit_c[SLOTS] && first_free[s]) begin
                wr[s] = 1'b1;
            end
            if (swap_now && fin_best != r_i) begin
                if (SW'(s) == r_i) begin
                    wr[s] = 1'b1;
                    wr_pc[s] = c_pc[fin_best];
                    wr_cnt[s] = c_cnt[fin_best];
                end else if (SW'(s) == fin_best) begin
                    wr[s] = 1'b1;
                    wr_pc[s] = c_pc[r_i];
                    wr_cnt[s] = c_cnt[r_i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
            r_st <= ST_IDLE;
            r_period <= PERIOD_RESET;
            r_evt <= 16'd0;
            r_taken <= 32'd0;
            r_evict <= 32'd0;
        end else begin
            o_valid <= n_valid;
            if (i_cfg_we) r_period <= i_cfg_data;
            unique case (r_st)
                ST_IDLE: begin
                    if (accept && i_opcode == OP_BRANCH) begin
                        r_evt <= n_evt;
                        if (do_sample) begin
                            r_taken <= r_taken + 32'd1;
                            if (!hit_c[SLOTS] && !free_c[SLOTS])
                                r_evict <= r_evict + 32'd1;
                        end
                    end else if (accept) begin
                        r_st <= ST_SUM;
                        r_j <= '0;
                        r_tot <= 32'd0;
                    end
                end
                ST_SUM: begin
                    r_tot <= r_tot + c_cnt[r_j];
                    if (r_j == SW'(SLOTS - 1)) begin
                        o_kind <= KIND_HEADER;
                        o_entry_pc <= 32'd0;
                        o_entry_count <= 32'd0;
                        o_sample_count <= r_taken;
                        o_samples_evicted <= r_evict;
                        o_total_count <= r_tot + c_cnt[r_j];
                        o_last <= !any_live;
                        r_st <= ST_SCAN;
                        r_i <= '0;
                        r_j <= '0;
                        r_pass <= '0;
                    end else begin
                        r_j <= r_j + SW'(1);
                    end
                end
                ST_SCAN: begin
                    if (swap_now) begin
                        o_sample_count <= 32'd0;
                        o_samples_evicted <= 32'd0;
                        o_total_count <= 32'd0;
                        if (fin_cnt == 32'd0) begin
                            r_st <= ST_CLR;
                        end else begin
                            o_kind <= KIND_ENTRY;
                            o_entry_pc <= c_pc[fin_best];
                            o_entry_count <= fin_cnt;
                            o_last <= pass_last;
                            if (pass_last) begin
                                r_st <= ST_CLR;
                            end
                        end
                        r_pass <= r_pass + LW'(1);
                        r_i <= r_i + SW'(1);
                        r_j <= r_i + SW'(1);
                    end else begin
                        r_j <= r_j + SW'(1);
                        if (r_j == r_i) begin
                            r_best <= r_j;
                            r_bcnt <= c_cnt[r_j];
                        end else if (c_cnt[r_j] > r_bcnt) begin
                            r_best <= r_j;
                            r_bcnt <= c_cnt[r_j];
                        end
                    end
                end
                ST_CLR: begin
                    r_st <= ST_IDLE;
                    r_evt <= 16'd0;
                    r_taken <= 32'd0;
                    r_evict <= 32'd0;
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end
endmodule
